/* rtl/assert_macros.svh */
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge while out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/crc8wfc_pkg.sv */
`timescale 1ns / 1ps

package crc8wfc_pkg;

    localparam int COUNT_W = 3;
    localparam int FW_EFF_W = 4;
    localparam int FRAME_SLOTS = 6;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [COUNT_W-1:0] FRAME_WORDS_RST = 3'd6;

    typedef enum logic [2:0] {
        PH_DATA_HI = 3'b001,
        PH_DATA_LO = 3'b010,
        PH_CRC     = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } in_item_t;

    typedef struct packed {
        logic [31:0] co2_bits;
        logic [31:0] temp_bits;
        logic [31:0] humidity_bits;
        logic [15:0] status_word;
        logic        data_ready;
        logic        crc_ok;
        logic [2:0]  first_bad_word;
    } out_item_t;

    typedef struct packed {
        logic               hi;
        logic               lo;
        logic [COUNT_W-1:0] slot;
        logic [7:0]         data;
    } store_wr_t;

    typedef struct packed {
        logic                emit;
        logic                crc_ok;
        logic [2:0]          first_bad;
        logic [FW_EFF_W-1:0] fw_eff;
    } frame_status_t;

    // CRC-8, MSB first, no reflection, no final XOR.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* rtl/crc8wfc_frame_ctrl.sv */
`timescale 1ns / 1ps

module crc8wfc_frame_ctrl #(
    parameter int MAX_WORDS = 6
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       step,
    input  crc8wfc_pkg::in_item_t                      item,
    input  logic [crc8wfc_pkg::COUNT_W-1:0]            frame_words,
    output crc8wfc_pkg::store_wr_t                     wr,
    output crc8wfc_pkg::frame_status_t                 status
);

    localparam logic [crc8wfc_pkg::FW_EFF_W-1:0] MaxWordsEff =
        crc8wfc_pkg::FW_EFF_W'(MAX_WORDS);

    crc8wfc_pkg::phase_t                phase_reg, phase_next, phase_v;
    logic [crc8wfc_pkg::COUNT_W-1:0]    count_reg, count_next, count_v;
    logic [7:0]                         crc_reg, crc_next, crc_v;
    logic                               err_reg, err_next, err_v, err_n;
    logic [2:0]                         bad_reg, bad_next, bad_v, bad_n;
    logic [crc8wfc_pkg::FW_EFF_W-1:0]   fw_eff;

    always_comb
    begin
        fw_eff = {1'b0, frame_words};
        if (frame_words == '0)
        begin
            fw_eff = crc8wfc_pkg::FW_EFF_W'(1);
        end
        else if (fw_eff > MaxWordsEff)
        begin
            fw_eff = MaxWordsEff;
        end
    end

    always_comb
    begin
        phase_v = phase_reg;
        count_v = count_reg;
        crc_v   = crc_reg;
        err_v   = err_reg;
        bad_v   = bad_reg;
        // A frame start restarts the frame and the byte is then the first data byte.
        if (item.frame_start)
        begin
            phase_v = crc8wfc_pkg::PH_DATA_HI;
            count_v = '0;
            crc_v   = crc8wfc_pkg::CRC_INIT;
            err_v   = 1'b0;
            bad_v   = '0;
        end

        phase_next = phase_v;
        count_next = count_v;
        crc_next   = crc_v;
        err_next   = err_v;
        bad_next   = bad_v;
        err_n      = err_v;
        bad_n      = bad_v;
        wr         = '0;
        wr.slot    = count_v;
        wr.data    = item.rx_byte;
        status     = '0;
        status.fw_eff = fw_eff;

        case (phase_v)
            crc8wfc_pkg::PH_DATA_HI:
            begin
                crc_next   = crc8wfc_pkg::crc8_byte(crc_v, item.rx_byte);
                wr.hi      = step;
                phase_next = crc8wfc_pkg::PH_DATA_LO;
            end
            crc8wfc_pkg::PH_DATA_LO:
            begin
                crc_next   = crc8wfc_pkg::crc8_byte(crc_v, item.rx_byte);
                wr.lo      = step;
                phase_next = crc8wfc_pkg::PH_CRC;
            end
            default:
            begin
                if (item.rx_byte != crc_v && !err_v)
                begin
                    err_n = 1'b1;
                    bad_n = count_v;
                end
                crc_next   = crc8wfc_pkg::CRC_INIT;
                phase_next = crc8wfc_pkg::PH_DATA_HI;
                err_next   = err_n;
                bad_next   = bad_n;
                if (({1'b0, count_v} + crc8wfc_pkg::FW_EFF_W'(1)) < fw_eff)
                begin
                    count_next = count_v + crc8wfc_pkg::COUNT_W'(1);
                end
                else
                begin
                    status.emit = step;
                    count_next  = '0;
                    err_next    = 1'b0;
                    bad_next    = '0;
                end
            end
        endcase

        status.crc_ok    = !err_n;
        status.first_bad = err_n ? bad_n : 3'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= crc8wfc_pkg::PH_DATA_HI;
            count_reg <= '0;
            crc_reg   <= crc8wfc_pkg::CRC_INIT;
            err_reg   <= 1'b0;
            bad_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            crc_reg   <= crc_next;
            err_reg   <= err_next;
            bad_reg   <= bad_next;
        end
    end

endmodule

/* rtl/crc8wfc_word_store.sv */
`timescale 1ns / 1ps

module crc8wfc_word_store #(
    parameter int MAX_WORDS = 6
) (
    input  logic                                             clk,
    input  crc8wfc_pkg::store_wr_t                           wr,
    input  logic [crc8wfc_pkg::FW_EFF_W-1:0]                 fw_eff,
    output logic [crc8wfc_pkg::FRAME_SLOTS-1:0][15:0]        words
);

    localparam int IdxW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

    logic [15:0]     store_reg [MAX_WORDS];
    logic [IdxW-1:0] idx;

    assign idx = wr.slot[IdxW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr.hi)
        begin
            store_reg[idx][15:8] <= wr.data;
        end
        if (wr.lo)
        begin
            store_reg[idx][7:0] <= wr.data;
        end
    end

    // Words beyond the frame length read as zero.
    for (genvar i = 0; i < crc8wfc_pkg::FRAME_SLOTS; i++)
    begin : g_read
        if (i < MAX_WORDS)
        begin : g_held
            assign words[i] = (crc8wfc_pkg::FW_EFF_W'(i) < fw_eff) ? store_reg[i] : 16'd0;
        end
        else
        begin : g_none
            assign words[i] = 16'd0;
        end
    end

endmodule

/* rtl/crc8_word_frame_checker.sv */
`timescale 1ns / 1ps
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_ready | in_item  (rx_byte, frame_start)
// out     | output    | out_valid/out_ready | out_item (words, flags, first_bad_word)
// cfg     | input     | cfg_valid/cfg_ready | cfg_data (frame_words)
//
// One byte is taken per cycle while in_ready is high; the CRC byte of the last word passes
// through the input register, and the result is then loaded into the result register.
// The CRC update for a byte is one unrolled eight-step stage between those registers.
// Reset is asynchronous and active low; frame_words returns to 6 and the frame restarts.
// A stalled result holds the output register; in_ready falls only when both stages are full.

`include "assert_macros.svh"

module crc8_word_frame_checker #(
    parameter int MAX_WORDS = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  crc8wfc_pkg::in_item_t             in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output crc8wfc_pkg::out_item_t            out_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [crc8wfc_pkg::COUNT_W-1:0]   cfg_data
);

    logic                                       in_valid_reg;
    crc8wfc_pkg::in_item_t                      in_item_reg;
    logic                                       out_valid_reg, out_valid_next;
    crc8wfc_pkg::out_item_t                     out_item_reg, out_item_next;
    logic [crc8wfc_pkg::COUNT_W-1:0]            frame_words_reg;
    logic                                       advance;
    logic                                       step;
    crc8wfc_pkg::store_wr_t                     wr;
    crc8wfc_pkg::frame_status_t                 status;
    logic [crc8wfc_pkg::FRAME_SLOTS-1:0][15:0]  words;

    assign advance   = !out_valid_reg || out_ready;
    assign step      = in_valid_reg && advance;
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_words_reg <= crc8wfc_pkg::FRAME_WORDS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            frame_words_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_item;
        end
    end

    crc8wfc_frame_ctrl #(
        .MAX_WORDS (MAX_WORDS)
    ) u_frame_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (in_item_reg),
        .frame_words (frame_words_reg),
        .wr          (wr),
        .status      (status)
    );

    crc8wfc_word_store #(
        .MAX_WORDS (MAX_WORDS)
    ) u_word_store (
        .clk    (clk),
        .wr     (wr),
        .fw_eff (status.fw_eff),
        .words  (words)
    );

    always_comb
    begin
        out_item_next.co2_bits       = {words[0], words[1]};
        out_item_next.temp_bits      = {words[2], words[3]};
        out_item_next.humidity_bits  = {words[4], words[5]};
        out_item_next.status_word    = words[0];
        out_item_next.data_ready     = (words[0] == 16'd1);
        out_item_next.crc_ok         = status.crc_ok;
        out_item_next.first_bad_word = status.first_bad;

        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (status.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.emit)
        begin
            out_item_reg <= out_item_next;
        end
    end

    `ASSERT_NEXT(a_emit_loads_result, clk, rst_n, status.emit, out_valid_reg,
        "finished frame lost")
    `ASSERT_CLK(a_emit_needs_slot, clk, rst_n, !status.emit || advance,
        "result register overrun")
    `ASSERT_CLK(a_ok_no_bad_index, clk, rst_n,
        !(out_valid_reg && out_item_reg.crc_ok) || out_item_reg.first_bad_word == 3'd0,
        "bad word index on a clean frame")
    `ASSERT_CLK(a_ready_flag, clk, rst_n,
        !out_valid_reg || (out_item_reg.data_ready == (out_item_reg.status_word == 16'd1)),
        "data-ready flag disagrees with status word")

endmodule

/* bench/tb_crc8_word_frame_checker.sv */
`timescale 1ns / 1ps

module tb_crc8_word_frame_checker;

    localparam int CYCLE_LIMIT = 400000;
    localparam int WORD_SLOTS = 6;
    localparam int REPORT_MAX = 10;
    localparam int SETTLE_CYCLES = 6;
    localparam int BYTES_PER_SETTING = 112;
    localparam logic [7:0] SENSOR_CRC_POLY = 8'h31;
    localparam logic [7:0] SENSOR_CRC_SEED = 8'hFF;

    class crc_frame_tracker;
        crc8wfc_pkg::out_item_t  pending_frames[$];
        int                      mismatches;
        logic [2:0]              frame_words;
        crc8wfc_pkg::phase_t     phase;
        logic [2:0]              word_pos;
        logic [7:0]              crc;
        logic [15:0]             words[8];
        bit                      err_seen;
        logic [2:0]              bad_idx;

        function new();
            mismatches = 0;
            frame_words = 3'd6;
            foreach (words[i])
            begin
                words[i] = 16'h0000;
            end
            restart();
        endfunction

        static function logic [7:0] crc8_next(logic [7:0] c, logic [7:0] d);
            logic [7:0] r;
            logic fb;
            r = c;
            for (int i = 7; i >= 0; i--)
            begin
                fb = r[7] ^ d[i];
                r = {r[6:0], 1'b0} ^ (fb ? SENSOR_CRC_POLY : 8'h00);
            end
            return r;
        endfunction

        // A length of zero behaves as one word; anything past the slot count is clipped.
        function int eff_words();
            if (frame_words == 3'd0)
            begin
                return 1;
            end
            if (frame_words > WORD_SLOTS)
            begin
                return WORD_SLOTS;
            end
            return int'(frame_words);
        endfunction

        function void restart();
            phase = crc8wfc_pkg::PH_DATA_HI;
            word_pos = 3'd0;
            crc = SENSOR_CRC_SEED;
            err_seen = 1'b0;
            bad_idx = 3'd0;
        endfunction

        function void note_byte(crc8wfc_pkg::in_item_t it);
            int fw;
            crc8wfc_pkg::out_item_t r;
            logic [15:0] w[6];
            fw = eff_words();
            if (it.frame_start)
            begin
                restart();
            end
            case (phase)
                crc8wfc_pkg::PH_DATA_HI:
                begin
                    crc = crc8_next(crc, it.rx_byte);
                    words[word_pos][15:8] = it.rx_byte;
                    phase = crc8wfc_pkg::PH_DATA_LO;
                end
                crc8wfc_pkg::PH_DATA_LO:
                begin
                    crc = crc8_next(crc, it.rx_byte);
                    words[word_pos][7:0] = it.rx_byte;
                    phase = crc8wfc_pkg::PH_CRC;
                end
                default:
                begin
                    if (it.rx_byte !== crc && !err_seen)
                    begin
                        err_seen = 1'b1;
                        bad_idx = word_pos;
                    end
                    crc = SENSOR_CRC_SEED;
                    phase = crc8wfc_pkg::PH_DATA_HI;
                    if (int'(word_pos) + 1 < fw)
                    begin
                        word_pos = word_pos + 3'd1;
                    end
                    else
                    begin
                        // Words beyond the frame length read as zero.
                        for (int i = 0; i < 6; i++)
                        begin
                            w[i] = (i < fw) ? words[i] : 16'h0000;
                        end
                        r.co2_bits = {w[0], w[1]};
                        r.temp_bits = {w[2], w[3]};
                        r.humidity_bits = {w[4], w[5]};
                        r.status_word = w[0];
                        r.data_ready = (w[0] == 16'd1);
                        r.crc_ok = !err_seen;
                        r.first_bad_word = err_seen ? bad_idx : 3'd0;
                        pending_frames.push_back(r);
                        restart();
                    end
                end
            endcase
        endfunction

        function void field_check(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("%0t %s: expected %h, got %h", $time, name, want, got);
                end
            end
        endfunction

        function void check_frame(crc8wfc_pkg::out_item_t got);
            crc8wfc_pkg::out_item_t want;
            if (pending_frames.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("%0t result with no frame outstanding: %h", $time, got);
                end
                return;
            end
            want = pending_frames.pop_front();
            field_check("co2_bits", want.co2_bits, got.co2_bits);
            field_check("temp_bits", want.temp_bits, got.temp_bits);
            field_check("humidity_bits", want.humidity_bits, got.humidity_bits);
            field_check("status_word", 32'(want.status_word), 32'(got.status_word));
            field_check("data_ready", 32'(want.data_ready), 32'(got.data_ready));
            field_check("crc_ok", 32'(want.crc_ok), 32'(got.crc_ok));
            field_check("first_bad_word", 32'(want.first_bad_word), 32'(got.first_bad_word));
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    crc8wfc_pkg::in_item_t           in_item;
    logic                            out_valid;
    logic                            out_ready;
    crc8wfc_pkg::out_item_t          out_item;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [crc8wfc_pkg::COUNT_W-1:0] cfg_data;

    int cycles = 0;
    int bytes_sent = 0;
    bit no_gaps = 1'b0;
    crc_frame_tracker tracker = new();

    crc8_word_frame_checker #(
        .MAX_WORDS(WORD_SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item(out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            tracker.check_frame(out_item);
        end
    end

    // Result side: mostly short ready and stall stretches, now and then a long stall or a long open stretch.
    initial
    begin : result_stalls
        int r;
        int len;
        bit on;
        out_ready = 1'b0;
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                on = 1'b1;
                len = $urandom_range(1, 4);
            end
            else if (r < 90)
            begin
                on = 1'b0;
                len = $urandom_range(1, 3);
            end
            else if (r < 95)
            begin
                on = 1'b0;
                len = $urandom_range(10, 40);
            end
            else
            begin
                on = 1'b1;
                len = $urandom_range(50, 200);
            end
            out_ready <= on;
            repeat (len) @(posedge clk);
        end
    end

    function int pick_gap();
        int r;
        if (no_gaps)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    task automatic send_byte(logic [7:0] b, bit fs);
        crc8wfc_pkg::in_item_t it;
        int gap;
        it.rx_byte = b;
        it.frame_start = fs;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        tracker.note_byte(it);
        bytes_sent++;
    endtask

    task automatic send_word(logic [15:0] w, bit fs, bit bad);
        logic [7:0] c;
        c = crc_frame_tracker::crc8_next(crc_frame_tracker::crc8_next(SENSOR_CRC_SEED, w[15:8]),
                                         w[7:0]);
        if (bad)
        begin
            c = c ^ 8'($urandom_range(1, 255));
        end
        send_byte(w[15:8], fs);
        send_byte(w[7:0], 1'b0);
        send_byte(c, 1'b0);
    endtask

    // Holds the input off until every frame has come out and the pipeline has emptied.
    task automatic settle_results();
        in_valid <= 1'b0;
        while (tracker.pending_frames.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_frame_words(logic [2:0] v);
        settle_results();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        tracker.frame_words = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_frame(bit force_start);
        int fw;
        int r;
        bit fs;
        logic [15:0] w;
        fw = tracker.eff_words();
        fs = force_start | 1'($urandom_range(0, 1));
        for (int i = 0; i < fw; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                w = 16'h0001;
            end
            else if (r < 15)
            begin
                w = 16'h0000;
            end
            else if (r < 20)
            begin
                w = 16'hFFFF;
            end
            else
            begin
                w = 16'($urandom);
            end
            send_word(w, fs && (i == 0), $urandom_range(0, 99) < 12);
        end
    endtask

    initial
    begin : stimulus
        logic [2:0] settings[9];
        int target;
        int r;
        int n;
        bit resync;
        settings = '{3'd6, 3'd3, 3'd7, 3'd1, 3'd5, 3'd0, 3'd2, 3'd4, 3'd6};
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames of one word: data ready, an all-one word with a bad CRC, an all-zero word.
        write_frame_words(3'd1);
        send_word(16'h0001, 1'b1, 1'b0);
        send_word(16'hFFFF, 1'b0, 1'b1);
        send_word(16'h0000, 1'b1, 1'b0);
        // A frame start in the middle of a word throws the partial word away.
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_word(16'h1234, 1'b1, 1'b0);
        write_frame_words(3'd0);
        send_word(16'h8000, 1'b0, 1'b0);
        // Shorten the frame after its first word so that it ends on the next CRC byte.
        write_frame_words(3'd2);
        send_word(16'h00FF, 1'b1, 1'b1);
        write_frame_words(3'd1);
        send_word(16'hBEEF, 1'b0, 1'b1);

        foreach (settings[s])
        begin
            write_frame_words(settings[s]);
            resync = 1'b1;
            target = bytes_sent + BYTES_PER_SETTING;
            while (bytes_sent < target)
            begin
                no_gaps = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 99);
                if (r < 80)
                begin
                    send_random_frame(resync);
                    resync = 1'b0;
                end
                else if (r < 90)
                begin
                    // Truncated frame; the next one has to resynchronise.
                    n = $urandom_range(1, 3 * tracker.eff_words() - 1);
                    send_byte(8'($urandom), 1'($urandom_range(0, 1)));
                    for (int i = 1; i < n; i++)
                    begin
                        send_byte(8'($urandom), 1'b0);
                    end
                    resync = 1'b1;
                end
                else
                begin
                    n = $urandom_range(1, 6);
                    for (int i = 0; i < n; i++)
                    begin
                        send_byte(8'($urandom), 1'($urandom_range(0, 1)));
                    end
                    resync = 1'b1;
                end
            end
        end
        no_gaps = 1'b0;

        settle_results();
        if (tracker.mismatches == 0 && tracker.pending_frames.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
